[hdl/cbpe_pkg.sv]
// Package for the cubic Bezier point evaluator.
// Fixed-point widths, register indexes and the weight bundle type.
// No dependencies.
`default_nettype none

package cbpe_pkg;

  localparam int FRAC_BITS = 9;
  localparam int T_W       = 10;
  localparam int COORD_W   = 16;
  localparam int REG_IDX_W = 3;

  localparam int TT_W    = 2 * FRAC_BITS + 1;
  localparam int TTT_W   = 3 * FRAC_BITS + 2;
  localparam int TT3_W   = 2 * FRAC_BITS + 3;
  localparam int TTT3_W  = 3 * FRAC_BITS + 3;
  localparam int C_W     = FRAC_BITS + 2;
  localparam int W_W     = FRAC_BITS + 4;
  localparam int PROD_W  = W_W + COORD_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_BITS);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [W_W-1:0] w0;
    logic signed [W_W-1:0] w1;
    logic signed [W_W-1:0] w2;
    logic signed [W_W-1:0] w3;
  } weights_t;

endpackage

`default_nettype wire

[hdl/cbpe_weights.sv]
// Four-stage pipeline forming the Bernstein weights from t.
// Clamp, t^2, t^3, then the weight adds. Uses cbpe_pkg.
`default_nettype none

module cbpe_weights (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cbpe_pkg::T_W-1:0]    t_in,
  output logic                             wt_valid,
  input  wire logic                        wt_ready,
  output cbpe_pkg::weights_t               wt
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic [cbpe_pkg::T_W-1:0]    s1_t;
  logic [cbpe_pkg::T_W-1:0]    s2_t;
  logic [cbpe_pkg::TT_W-1:0]   s2_tt;
  logic [cbpe_pkg::TT_W-1:0]   s3_tt;
  logic [cbpe_pkg::TTT_W-1:0]  s3_ttt;
  cbpe_pkg::weights_t          s4_w;

  // t kept alongside t^3 for the linear term
  logic [cbpe_pkg::T_W-1:0] s3_tt_t;

  logic [cbpe_pkg::T_W-1:0]    t_clamp;
  logic [cbpe_pkg::TT3_W-1:0]  tt3;
  logic [cbpe_pkg::TTT3_W-1:0] ttt3;
  logic [cbpe_pkg::C_W-1:0]    c1, c2, c3, w3u;
  logic signed [cbpe_pkg::W_W-1:0] c1s, c2s, c3s, w3s;
  cbpe_pkg::weights_t          w_next;

  function automatic logic [cbpe_pkg::C_W-1:0] s3_t_x3(input logic [cbpe_pkg::T_W-1:0] t);
    logic [cbpe_pkg::C_W-1:0] te;
    te = cbpe_pkg::C_W'(t);
    return te + (te << 1);
  endfunction

  assign en4      = !v4 || wt_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign wt_valid = v4;
  assign wt       = s4_w;

  assign t_clamp = (t_in > cbpe_pkg::T_ONE) ? cbpe_pkg::T_ONE : t_in;

  always_comb begin
    tt3  = cbpe_pkg::TT3_W'(s3_tt) + (cbpe_pkg::TT3_W'(s3_tt) << 1);
    ttt3 = cbpe_pkg::TTT3_W'(s3_ttt) + (cbpe_pkg::TTT3_W'(s3_ttt) << 1);
    c1   = cbpe_pkg::C_W'(s3_t_x3(s3_tt_t));
    c2   = tt3[cbpe_pkg::FRAC_BITS +: cbpe_pkg::C_W];
    c3   = ttt3[2 * cbpe_pkg::FRAC_BITS +: cbpe_pkg::C_W];
    w3u  = s3_ttt[2 * cbpe_pkg::FRAC_BITS +: cbpe_pkg::C_W];
    c1s  = signed'(cbpe_pkg::W_W'(c1));
    c2s  = signed'(cbpe_pkg::W_W'(c2));
    c3s  = signed'(cbpe_pkg::W_W'(c3));
    w3s  = signed'(cbpe_pkg::W_W'(w3u));
    w_next.w0 = signed'(cbpe_pkg::W_W'(cbpe_pkg::T_ONE)) + c2s - c1s - w3s;
    w_next.w1 = c3s - (c2s <<< 1) + c1s;
    w_next.w2 = c2s - c3s;
    w_next.w3 = w3s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_t <= t_clamp;
    end
    if (en2) begin
      s2_t  <= s1_t;
      s2_tt <= cbpe_pkg::TT_W'(s1_t * s1_t);
    end
    if (en3) begin
      s3_tt_t <= s2_t;
      s3_tt   <= s2_tt;
      s3_ttt  <= cbpe_pkg::TTT_W'(s2_tt * s2_t);
    end
    if (en4) begin
      s4_w <= w_next;
    end
  end

endmodule

`default_nettype wire

[hdl/cubic_bezier_point_eval.sv]
// Top level of the cubic Bezier point evaluator: control point registers,
// weight pipeline (cbpe_weights) and the two-stage weighted sum. Uses cbpe_pkg.
//
// Usage:
//   Write the four control points through cfg_we / cfg_idx / cfg_wdata while
//   the block is idle (index 0..7: p0_x, p0_y, p1_x, p1_y, ... p3_y).
//   Each input beat (in_valid & in_ready) carries t_param, 512 = 1.0; larger
//   values are clamped to 512. Each output beat (out_valid & out_ready)
//   carries point_x / point_y, the curve point truncated to 16 bits.
//   From input beat to out_valid a beat passes through six register
//   stages: clamp, t^2, t^3, weights, eight 13x16 products, then the two
//   four-term sums.
//   Throughput is one beat per cycle while out_ready stays high; every stage
//   holds a valid bit and advances when the stage after it is empty or moving.
//   When out_ready is low the pipeline fills and in_ready drops once all six
//   stages hold beats; nothing is dropped or repeated.
//   Reset clears all valid bits and the control points to 0.
`default_nettype none

module cubic_bezier_point_eval (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [cbpe_pkg::REG_IDX_W-1:0]         cfg_idx,
  input  wire logic [cbpe_pkg::COORD_W-1:0]           cfg_wdata,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [cbpe_pkg::T_W-1:0]               t_param,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [cbpe_pkg::COORD_W-1:0]         point_x,
  output logic signed [cbpe_pkg::COORD_W-1:0]         point_y
);

  localparam int NPTS = 4;

  logic signed [cbpe_pkg::COORD_W-1:0] px [NPTS];
  logic signed [cbpe_pkg::COORD_W-1:0] py [NPTS];

  logic               wt_valid, wt_ready;
  cbpe_pkg::weights_t wt;
  logic signed [cbpe_pkg::W_W-1:0] wv [NPTS];

  logic v5, en5, en6;
  logic signed [cbpe_pkg::PROD_W-1:0] prod_x [NPTS];
  logic signed [cbpe_pkg::PROD_W-1:0] prod_y [NPTS];
  logic signed [cbpe_pkg::ACC_W-1:0]  sum_x, sum_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NPTS; i++) begin
        px[i] <= '0;
        py[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cbpe_pkg::reg_idx_t'(cfg_idx))
        cbpe_pkg::REG_P0_X: px[0] <= cfg_wdata;
        cbpe_pkg::REG_P0_Y: py[0] <= cfg_wdata;
        cbpe_pkg::REG_P1_X: px[1] <= cfg_wdata;
        cbpe_pkg::REG_P1_Y: py[1] <= cfg_wdata;
        cbpe_pkg::REG_P2_X: px[2] <= cfg_wdata;
        cbpe_pkg::REG_P2_Y: py[2] <= cfg_wdata;
        cbpe_pkg::REG_P3_X: px[3] <= cfg_wdata;
        cbpe_pkg::REG_P3_Y: py[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cbpe_weights u_weights (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .t_in     (t_param),
    .wt_valid (wt_valid),
    .wt_ready (wt_ready),
    .wt       (wt)
  );

  assign en6      = !out_valid || out_ready;
  assign en5      = !v5 || en6;
  assign wt_ready = en5;

  assign wv[0] = wt.w0;
  assign wv[1] = wt.w1;
  assign wv[2] = wt.w2;
  assign wv[3] = wt.w3;

  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int i = 0; i < NPTS; i++) begin
      sum_x = sum_x + cbpe_pkg::ACC_W'(prod_x[i]);
      sum_y = sum_y + cbpe_pkg::ACC_W'(prod_y[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en5) v5 <= wt_valid;
      if (en6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int i = 0; i < NPTS; i++) begin
        prod_x[i] <= cbpe_pkg::PROD_W'(wv[i] * px[i]);
        prod_y[i] <= cbpe_pkg::PROD_W'(wv[i] * py[i]);
      end
    end
    if (en6) begin
      // floor shift by FRAC_BITS, keep low 16 bits
      point_x <= sum_x[cbpe_pkg::FRAC_BITS +: cbpe_pkg::COORD_W];
      point_y <= sum_y[cbpe_pkg::FRAC_BITS +: cbpe_pkg::COORD_W];
    end
  end

endmodule

`default_nettype wire

[tb/cbpe_checker.sv]
// Checker for cubic_bezier_point_eval: mirrors the control point registers,
// predicts each curve point from t and matches it against the output beats.
// Depends on cbpe_pkg.
`timescale 1ns / 1ps

module cbpe_checker
  import cbpe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [REG_IDX_W-1:0]  cfg_idx,
  input  wire logic [COORD_W-1:0]    cfg_wdata,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [T_W-1:0]        t_param,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [COORD_W-1:0]    point_x,
  input  wire logic [COORD_W-1:0]    point_y,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  logic signed [COORD_W-1:0] ctrl_pts [8];
  point_t                    curve_pts_q [$];

  function automatic point_t bezier_point(input logic [T_W-1:0] t_raw);
    longint t, tt, ttt, c1, c2, c3, w0, w1, w2, w3, sx, sy;
    point_t p;
    t   = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
    tt  = t * t;
    ttt = tt * t;
    c3  = (3 * ttt) >>> (2 * FRAC_BITS);
    c2  = (3 * tt) >>> FRAC_BITS;
    c1  = 3 * t;
    w3  = ttt >>> (2 * FRAC_BITS);
    w0  = -w3 + c2 - c1 + (longint'(1) << FRAC_BITS);
    w1  = c3 - 2 * c2 + c1;
    w2  = -c3 + c2;
    sx  = w0 * longint'(ctrl_pts[REG_P0_X]) + w1 * longint'(ctrl_pts[REG_P1_X]) +
          w2 * longint'(ctrl_pts[REG_P2_X]) + w3 * longint'(ctrl_pts[REG_P3_X]);
    sy  = w0 * longint'(ctrl_pts[REG_P0_Y]) + w1 * longint'(ctrl_pts[REG_P1_Y]) +
          w2 * longint'(ctrl_pts[REG_P2_Y]) + w3 * longint'(ctrl_pts[REG_P3_Y]);
    // floor shift, then keep the low 16 bits
    p.x = COORD_W'(sx >>> FRAC_BITS);
    p.y = COORD_W'(sy >>> FRAC_BITS);
    return p;
  endfunction

  always @(posedge clk) begin
    point_t want;
    int     errs;
    errs = 0;
    if (rst) begin
      foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
      curve_pts_q.delete();
    end else begin
      if (cfg_we) ctrl_pts[cfg_idx] = cfg_wdata;
      if (in_valid && in_ready) curve_pts_q.push_back(bezier_point(t_param));
      if (out_valid && out_ready) begin
        if (curve_pts_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual x=%0d y=%0d",
                   $time, $signed(point_x), $signed(point_y));
          errs++;
        end else begin
          want = curve_pts_q.pop_front();
          if (point_x !== want.x) begin
            $display("%0t: point_x mismatch, expected %0d, actual %0d",
                     $time, $signed(want.x), $signed(point_x));
            errs++;
          end
          if (point_y !== want.y) begin
            $display("%0t: point_y mismatch, expected %0d, actual %0d",
                     $time, $signed(want.y), $signed(point_y));
            errs++;
          end
        end
      end
    end
    fail_count <= fail_count + errs;
    pending    <= curve_pts_q.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top for cubic_bezier_point_eval: clock, reset, control point
// writes, t stimulus, output back-pressure, watchdog and verdict.
// Depends on cbpe_pkg and cbpe_checker.
`timescale 1ns / 1ps

module tb_top;
  import cbpe_pkg::*;

  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int HOLD_CYCLES      = 120;
  localparam int CURVES_PER_PHASE = 5;
  localparam int POINTS_PER_CURVE = 95;
  localparam int T_MAX            = (1 << T_W) - 1;

  localparam int SEND_IDLE_PCT  [4] = '{0, 64, 0, 26};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 64, 26};

  localparam logic [T_W-1:0] SWEEP_T [16] = '{
    10'd0, 10'd1, 10'd2, 10'd3, 10'd255, 10'd256, 10'd257, 10'd510,
    10'd511, 10'd512, 10'd513, 10'd1023, 10'd341, 10'd682, 10'd768, 10'd1022
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx   = '0;
  logic [COORD_W-1:0]   cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [T_W-1:0]       t_param   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   point_x;
  logic [COORD_W-1:0]   point_y;

  int   fail_count;
  int   pending;
  int   send_idle    = 0;
  int   recv_stall   = 0;
  logic long_hold    = 1'b0;
  int   hold_cnt     = 0;
  int   quiet_cycles = 0;

  logic [COORD_W-1:0] curve [8];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cubic_bezier_point_eval u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .t_param   (t_param),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y)
  );

  cbpe_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .t_param    (t_param),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // output side: random stalls, or a long hold-off while long_hold is set
  always @(posedge clk) begin
    if (long_hold && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
      if (!long_hold) hold_cnt <= 0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_point(input logic [T_W-1:0] t);
    in_valid <= 1'b1;
    t_param  <= t;
    do @(posedge clk); while (!in_ready);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_curve();
    reg_idx_t r;
    r = REG_P0_X;
    do begin
      cfg_we    <= 1'b1;
      cfg_idx   <= r;
      cfg_wdata <= curve[r];
      @(posedge clk);
      r = r.next();
    end while (r != REG_P0_X);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_t();
    case ($urandom_range(9))
      0:       return T_ONE;
      1:       return T_W'($urandom_range(T_MAX, int'(T_ONE) + 1));
      2:       return '0;
      default: return T_W'($urandom_range(int'(T_ONE), 0));
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // control points still at reset
    send_point('0);
    send_point(T_ONE);
    drain();

    // P0 opposite to the rest: truncated weights push the sum past 16 bits
    curve = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
              16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    load_curve();
    foreach (SWEEP_T[i]) send_point(SWEEP_T[i]);
    drain();

    curve = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
              16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    load_curve();
    send_point(10'd0);
    send_point(10'd128);
    send_point(10'd512);
    send_point(10'd1023);
    send_point(10'd511);
    send_point(10'd384);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle  <= SEND_IDLE_PCT[p];
      recv_stall <= RECV_STALL_PCT[p];
      for (int c = 0; c < CURVES_PER_PHASE; c++) begin
        foreach (curve[i]) curve[i] = rand_coord();
        load_curve();
        if (p == 0 && c == 0) begin
          // fill the pipeline against a held-off output
          long_hold <= 1'b1;
          repeat (24) send_point(rand_t());
          long_hold <= 1'b0;
        end
        repeat (POINTS_PER_CURVE) send_point(rand_t());
        drain();
      end
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
